/* design/hsv_to_rgb_with_brightness_cap_macros.svh */
// Assertion macros shared by the color conversion RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef HSV_TO_RGB_WITH_BRIGHTNESS_CAP_MACROS_SVH
`define HSV_TO_RGB_WITH_BRIGHTNESS_CAP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsvrgb check failed");
// Next-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsvrgb check failed");
`else
`define HSVRGB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/hsvrgb_pkg.sv */
// Types, constants and helper functions for the HSV to RGB converter.
// No dependencies; used by the top level.
package hsvrgb_pkg;

    // Input transfer payload.
    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  value;
    } t_hsv;

    // Output transfer payload.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // 60-degree sectors of the color wheel, named by the hues they span.
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    localparam logic [7:0]  CAP_RESET    = 8'd255;
    localparam logic [7:0]  FULL_SCALE   = 8'd255;
    localparam logic [8:0]  HUE_WRAP     = 9'd360;
    localparam logic [5:0]  SECTOR_SPAN  = 6'd60;
    // floor(hue * 182 / 2^16) is the hue quotient by 360, or one below it.
    localparam logic [7:0]  HUE_DIV_MUL  = 8'd182;
    // floor(x * 0x8081 / 2^23) equals floor(x / 255) for every 16-bit x.
    localparam logic [15:0] DIV255_MUL   = 16'h8081;
    // floor(z * 1118482 / 2^24) equals floor(z / 15) for every 20-bit z.
    localparam logic [20:0] DIV15_MUL    = 21'd1118482;

    // Q16 form of an 8-bit fraction of 255: n*257 plus one at full scale.
    function automatic logic [16:0] to_q16(input logic [7:0] n);
        logic [16:0] res;
        res = {1'b0, n, n} + 17'(n == FULL_SCALE);
        return res;
    endfunction

    // Q16 level to an 8-bit channel: floor(s * 255 / 2^16).
    function automatic logic [7:0] to_channel(input logic [16:0] s);
        logic [24:0] prod;
        prod = {s, 8'b0} - {8'b0, s};
        return prod[23:16];
    endfunction

endpackage

/* design/hsv_to_rgb_with_brightness_cap.sv */
// HSV to RGB converter with a global brightness cap, six register stages.
// Throughput: one item per cycle; the pipeline holds only while a result waits on a stall.
// Reset (synchronous, active low) empties the pipeline and sets the cap to full scale.
// Depends on hsvrgb_pkg and the assertion macro header.
`include "hsv_to_rgb_with_brightness_cap_macros.svh"

module hsv_to_rgb_with_brightness_cap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  hsvrgb_pkg::t_hsv   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output hsvrgb_pkg::t_rgb   o_data
);

    logic                r_cap;
    logic [7:0]          r_cap_val;
    logic [5:0]          r_vld;
    logic                w_adv;

    // Stage 1 registers.
    logic [15:0]         r1_hue;
    logic [7:0]          r1_hq;
    logic [16:0]         r1_sq;
    logic [15:0]         r1_vc;
    // Stage 2 registers.
    logic [7:0]          r2_capped;
    logic [8:0]          r2_h;
    logic [16:0]         r2_sq;
    // Stage 3 registers.
    logic [16:0]         r3_vq;
    logic [16:0]         r3_cq;
    hsvrgb_pkg::t_sector r3_sec;
    logic [5:0]          r3_t;
    // Stage 4 registers.
    logic [21:0]         r4_y;
    logic [16:0]         r4_cq;
    logic [16:0]         r4_mq;
    hsvrgb_pkg::t_sector r4_sec;
    // Stage 5 registers.
    logic [16:0]         r5_xq;
    logic [16:0]         r5_cq;
    logic [16:0]         r5_mq;
    hsvrgb_pkg::t_sector r5_sec;
    // Output register.
    hsvrgb_pkg::t_rgb    r_out;

    // Next values.
    logic [15:0]         n1_vc;
    logic [23:0]         w1_hprod;
    logic [16:0]         n1_sq;
    logic [31:0]         w2_cprod;
    logic [9:0]          w2_hraw;
    logic [8:0]          n2_h;
    logic [16:0]         n3_vq;
    logic [33:0]         w3_cprod;
    hsvrgb_pkg::t_sector n3_sec;
    logic [8:0]          w3_base;
    logic [5:0]          w3_f;
    logic [5:0]          n3_t;
    logic [21:0]         n4_y;
    logic [40:0]         w5_xprod;
    logic [16:0]         w6_rp;
    logic [16:0]         w6_gp;
    logic [16:0]         w6_bp;
    hsvrgb_pkg::t_rgb    n_out;

    // The pipeline moves unless a finished result is waiting on a stalled output.
    assign w_adv   = !r_vld[5] || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_vld[5];
    assign o_data  = r_out;

    // Brightness cap register; r_cap marks that a write was seen since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= 1'b0;
            r_cap_val <= hsvrgb_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap     <= 1'b1;
            r_cap_val <= i_cfg_wdata;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // Stage 1: value times cap, first hue quotient estimate, saturation in Q16.
    always_comb begin
        n1_vc    = 16'(i_data.value) * 16'(r_cap_val);
        w1_hprod = 24'(i_data.hue) * 24'(hsvrgb_pkg::HUE_DIV_MUL);
        n1_sq    = hsvrgb_pkg::to_q16(i_data.saturation);
    end

    // Stage 2: divide the capped product by 255, finish hue modulo 360.
    always_comb begin
        w2_cprod = 32'(r1_vc) * 32'(hsvrgb_pkg::DIV255_MUL);
        w2_hraw  = 10'(r1_hue - 16'(r1_hq * 16'(hsvrgb_pkg::HUE_WRAP)));
        if (w2_hraw >= 10'(hsvrgb_pkg::HUE_WRAP)) begin
            n2_h = 9'(w2_hraw - 10'(hsvrgb_pkg::HUE_WRAP));
        end else begin
            n2_h = w2_hraw[8:0];
        end
    end

    // Stage 3: value in Q16, chroma, sector and position inside it.
    always_comb begin
        n3_vq    = hsvrgb_pkg::to_q16(r2_capped);
        w3_cprod = 34'(n3_vq) * 34'(r2_sq);
        priority if (r2_h < 9'd60) begin
            n3_sec  = hsvrgb_pkg::SEC_RY;
            w3_base = 9'd0;
        end else if (r2_h < 9'd120) begin
            n3_sec  = hsvrgb_pkg::SEC_YG;
            w3_base = 9'd60;
        end else if (r2_h < 9'd180) begin
            n3_sec  = hsvrgb_pkg::SEC_GC;
            w3_base = 9'd120;
        end else if (r2_h < 9'd240) begin
            n3_sec  = hsvrgb_pkg::SEC_CB;
            w3_base = 9'd180;
        end else if (r2_h < 9'd300) begin
            n3_sec  = hsvrgb_pkg::SEC_BM;
            w3_base = 9'd240;
        end else begin
            n3_sec  = hsvrgb_pkg::SEC_MR;
            w3_base = 9'd300;
        end
        w3_f = 6'(r2_h - w3_base);
        // Odd sectors fall, even sectors rise.
        if (n3_sec[0]) begin
            n3_t = hsvrgb_pkg::SECTOR_SPAN - w3_f;
        end else begin
            n3_t = w3_f;
        end
    end

    // Stage 4: chroma times the sector position.
    assign n4_y = 22'(r3_cq) * 22'(r3_t);

    // Stage 5: divide by 60 as a shift by two and a reciprocal multiply by 15.
    assign w5_xprod = 41'(r4_y[21:2]) * 41'(hsvrgb_pkg::DIV15_MUL);

    // Stage 6: place chroma and secondary in their channels, add offset, scale.
    always_comb begin
        w6_rp = '0;
        w6_gp = '0;
        w6_bp = '0;
        unique case (r5_sec)
            hsvrgb_pkg::SEC_RY: begin
                w6_rp = r5_cq;
                w6_gp = r5_xq;
            end
            hsvrgb_pkg::SEC_YG: begin
                w6_rp = r5_xq;
                w6_gp = r5_cq;
            end
            hsvrgb_pkg::SEC_GC: begin
                w6_gp = r5_cq;
                w6_bp = r5_xq;
            end
            hsvrgb_pkg::SEC_CB: begin
                w6_gp = r5_xq;
                w6_bp = r5_cq;
            end
            hsvrgb_pkg::SEC_BM: begin
                w6_rp = r5_xq;
                w6_bp = r5_cq;
            end
            default: begin
                w6_rp = r5_cq;
                w6_bp = r5_xq;
            end
        endcase
        n_out.red   = hsvrgb_pkg::to_channel(w6_rp + r5_mq);
        n_out.green = hsvrgb_pkg::to_channel(w6_gp + r5_mq);
        n_out.blue  = hsvrgb_pkg::to_channel(w6_bp + r5_mq);
    end

    // Datapath registers, no reset.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_hue    <= i_data.hue;
            r1_hq     <= w1_hprod[23:16];
            r1_sq     <= n1_sq;
            r1_vc     <= n1_vc;
            r2_capped <= w2_cprod[30:23];
            r2_h      <= n2_h;
            r2_sq     <= r1_sq;
            r3_vq     <= n3_vq;
            r3_cq     <= w3_cprod[32:16];
            r3_sec    <= n3_sec;
            r3_t      <= n3_t;
            r4_y      <= n4_y;
            r4_cq     <= r3_cq;
            r4_mq     <= r3_vq - r3_cq;
            r4_sec    <= r3_sec;
            r5_xq     <= w5_xprod[40:24];
            r5_cq     <= r4_cq;
            r5_mq     <= r4_mq;
            r5_sec    <= r4_sec;
            r_out     <= n_out;
        end
    end

    // A stall toward the source only comes from a held result.
    `HSVRGB_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid)
    // An item in the last stage reaches the output when the pipeline moves.
    `HSVRGB_ASSERT_NEXT(a_last_stage_moves, i_clk, i_rst_n, r_vld[4] && w_adv, o_valid)
    // The hue is fully reduced after stage 2.
    `HSVRGB_ASSERT_IMPL(a_hue_reduced, i_clk, i_rst_n, r_vld[1], r2_h < 9'd360)
    // Secondary component never exceeds chroma.
    `HSVRGB_ASSERT_IMPL(a_x_below_c, i_clk, i_rst_n, r_vld[4], r5_xq <= r5_cq)
    // Without a cap write, the cap stays at full scale.
    `HSVRGB_ASSERT_IMPL(a_cap_default, i_clk, i_rst_n, !r_cap, r_cap_val == 8'd255)

endmodule
